@@ rtl/sae_pkg.sv @@
// Shared types and constants for the suffix automaton extend block.
package sae_pkg;

    // Fixed port widths
    localparam int SYMBOL_W = 5;
    localparam int STATE_W  = 10;
    localparam int LENGTH_W = 10;
    localparam int USED_W   = 11;
    // Width used to range-check an incoming symbol (alphabet up to 256)
    localparam int SYMCMP_W = 9;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SETCUR,
        S_CLRROW,
        S_WALK_RD,
        S_WALK_CHK,
        S_CMP,
        S_COPY,
        S_CLONE_META,
        S_RED_RD,
        S_RED_CHK,
        S_LINKQ,
        S_LINKCUR,
        S_FIN_RD,
        S_FIN,
        S_EMIT
    } fsm_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR0,
        OP_ACCEPT,
        OP_SETCUR,
        OP_CLRROW,
        OP_WALK_RD,
        OP_WALK_CHK,
        OP_CMP,
        OP_COPY,
        OP_CLONE_META,
        OP_RED_RD,
        OP_RED_CHK,
        OP_LINKQ,
        OP_LINKCUR,
        OP_FIN_RD,
        OP_FIN,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic sym_bad;
        logic no_room;
        logic t_zero;
        logic t_is_q;
        logic p_zero;
        logic len_match;
        logic idx_last;
        logic idx_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/sae_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sae_ctrl.sv @@
// Sequencer for the suffix automaton extend step.
module sae_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sae_pkg::dp_status_t status,
    output sae_pkg::dp_cmd_t    cmd
);

    sae_pkg::fsm_state_t state_reg;
    sae_pkg::fsm_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sae_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != sae_pkg::S_IDLE);

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = sae_pkg::OP_NONE;
        case (state_reg)
            sae_pkg::S_CLEAR:
            begin
                cmd.op = sae_pkg::OP_CLR0;
                if (status.idx_last)
                begin
                    state_next = sae_pkg::S_IDLE;
                end
            end
            sae_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = sae_pkg::OP_ACCEPT;
                    if (status.sym_bad || status.no_room)
                    begin
                        state_next = sae_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = sae_pkg::S_SETCUR;
                    end
                end
            end
            sae_pkg::S_SETCUR:
            begin
                cmd.op     = sae_pkg::OP_SETCUR;
                state_next = sae_pkg::S_CLRROW;
            end
            sae_pkg::S_CLRROW:
            begin
                cmd.op = sae_pkg::OP_CLRROW;
                if (status.idx_last)
                begin
                    state_next = sae_pkg::S_WALK_RD;
                end
            end
            sae_pkg::S_WALK_RD:
            begin
                cmd.op     = sae_pkg::OP_WALK_RD;
                state_next = sae_pkg::S_WALK_CHK;
            end
            sae_pkg::S_WALK_CHK:
            begin
                cmd.op = sae_pkg::OP_WALK_CHK;
                if (!status.t_zero)
                begin
                    state_next = sae_pkg::S_CMP;
                end
                else if (status.p_zero)
                begin
                    state_next = sae_pkg::S_FIN_RD;
                end
                else
                begin
                    state_next = sae_pkg::S_WALK_RD;
                end
            end
            sae_pkg::S_CMP:
            begin
                cmd.op = sae_pkg::OP_CMP;
                if (status.len_match)
                begin
                    state_next = sae_pkg::S_FIN_RD;
                end
                else
                begin
                    state_next = sae_pkg::S_COPY;
                end
            end
            sae_pkg::S_COPY:
            begin
                cmd.op = sae_pkg::OP_COPY;
                if (status.idx_done)
                begin
                    state_next = sae_pkg::S_CLONE_META;
                end
            end
            sae_pkg::S_CLONE_META:
            begin
                cmd.op     = sae_pkg::OP_CLONE_META;
                state_next = sae_pkg::S_RED_RD;
            end
            sae_pkg::S_RED_RD:
            begin
                cmd.op     = sae_pkg::OP_RED_RD;
                state_next = sae_pkg::S_RED_CHK;
            end
            sae_pkg::S_RED_CHK:
            begin
                cmd.op = sae_pkg::OP_RED_CHK;
                if (!status.t_is_q || status.p_zero)
                begin
                    state_next = sae_pkg::S_LINKQ;
                end
                else
                begin
                    state_next = sae_pkg::S_RED_RD;
                end
            end
            sae_pkg::S_LINKQ:
            begin
                cmd.op     = sae_pkg::OP_LINKQ;
                state_next = sae_pkg::S_LINKCUR;
            end
            sae_pkg::S_LINKCUR:
            begin
                cmd.op     = sae_pkg::OP_LINKCUR;
                state_next = sae_pkg::S_FIN_RD;
            end
            sae_pkg::S_FIN_RD:
            begin
                cmd.op     = sae_pkg::OP_FIN_RD;
                state_next = sae_pkg::S_FIN;
            end
            sae_pkg::S_FIN:
            begin
                cmd.op     = sae_pkg::OP_FIN;
                state_next = sae_pkg::S_EMIT;
            end
            sae_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = sae_pkg::OP_EMIT;
                    state_next = sae_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sae_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sae_dp.sv @@
// Datapath: automaton stores, walk registers and the result register.
module sae_dp #(
    parameter int MAX_STATES = 1024,
    parameter int ALPHABET   = 26
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sae_pkg::dp_cmd_t                 cmd,
    output sae_pkg::dp_status_t              status,
    input  logic [sae_pkg::SYMBOL_W-1:0]     symbol,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sae_pkg::STATE_W-1:0]      new_state,
    output logic [sae_pkg::STATE_W-1:0]      link_state,
    output logic [sae_pkg::LENGTH_W-1:0]     new_length,
    output logic [sae_pkg::LENGTH_W-1:0]     distinct_added,
    output logic [sae_pkg::USED_W-1:0]       states_used,
    output logic                             store_full
);

    localparam int ST_W  = $clog2(MAX_STATES);
    localparam int CNT_W = $clog2(MAX_STATES + 1);
    localparam int SYM_W = $clog2(ALPHABET);
    localparam int IDX_W = $clog2(ALPHABET + 1);
    localparam int TA_D  = MAX_STATES * ALPHABET;
    localparam int TA_W  = $clog2(TA_D);

    // Control registers
    logic [CNT_W-1:0] count_reg;
    logic [ST_W-1:0]  last_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;

    // Working registers
    logic [SYM_W-1:0] sym_reg;
    logic [ST_W-1:0]  cur_reg;
    logic [ST_W-1:0]  p_reg;
    logic [ST_W-1:0]  q_reg;
    logic [ST_W-1:0]  clone_reg;
    logic [ST_W-1:0]  lnk_reg;
    logic [ST_W-1:0]  linkq_reg;
    logic [CNT_W-1:0] lenp_reg;
    logic [CNT_W-1:0] lencur_reg;

    // Result and output registers
    logic [ST_W-1:0]  res_new_reg;
    logic [ST_W-1:0]  res_link_reg;
    logic [CNT_W-1:0] res_len_reg;
    logic [CNT_W-1:0] res_da_reg;
    logic [CNT_W-1:0] res_used_reg;
    logic             res_full_reg;
    logic [sae_pkg::STATE_W-1:0]  out_new_reg;
    logic [sae_pkg::STATE_W-1:0]  out_link_reg;
    logic [sae_pkg::LENGTH_W-1:0] out_len_reg;
    logic [sae_pkg::LENGTH_W-1:0] out_da_reg;
    logic [sae_pkg::USED_W-1:0]   out_used_reg;
    logic                         out_full_reg;

    // Memory ports
    logic             ta_we;
    logic [TA_W-1:0]  ta_waddr;
    logic [ST_W-1:0]  ta_wdata;
    logic             ta_re;
    logic [TA_W-1:0]  ta_raddr;
    logic [ST_W-1:0]  ta_rd;
    logic             ln_we;
    logic [ST_W-1:0]  ln_waddr;
    logic [CNT_W-1:0] ln_wdata;
    logic             ln_re;
    logic [ST_W-1:0]  ln_raddr;
    logic [CNT_W-1:0] ln_rd;
    logic             lk_we;
    logic [ST_W-1:0]  lk_waddr;
    logic [ST_W-1:0]  lk_wdata;
    logic             lk_re;
    logic [ST_W-1:0]  lk_raddr;
    logic [ST_W-1:0]  lk_rd;

    logic [TA_W-1:0]  pc_addr;
    logic [TA_W-1:0]  cur_row;
    logic [TA_W-1:0]  q_row;
    logic [TA_W-1:0]  clone_row;
    logic [TA_W-1:0]  idx_ext;
    logic [TA_W-1:0]  idx_prev;
    logic [CNT_W-1:0] lenp_inc;
    logic             sym_bad;
    logic             no_room;
    logic             out_free;

    // Row addressing into the transition store
    assign pc_addr   = TA_W'(TA_W'(p_reg) * TA_W'(ALPHABET) + TA_W'(sym_reg));
    assign cur_row   = TA_W'(TA_W'(cur_reg) * TA_W'(ALPHABET));
    assign q_row     = TA_W'(TA_W'(q_reg) * TA_W'(ALPHABET));
    assign clone_row = TA_W'(TA_W'(clone_reg) * TA_W'(ALPHABET));
    assign idx_ext   = TA_W'(idx_reg);
    assign idx_prev  = TA_W'(idx_reg - IDX_W'(1));
    assign lenp_inc  = lenp_reg + CNT_W'(1);

    // Request checks
    assign sym_bad  = (sae_pkg::SYMCMP_W'(symbol) >= sae_pkg::SYMCMP_W'(ALPHABET));
    assign no_room  = ((CNT_W+1)'(count_reg) + (CNT_W+1)'(2)) > (CNT_W+1)'(MAX_STATES);
    assign out_free = !out_valid_reg || !out_stall;

    // Status to the controller
    always_comb
    begin
        status.sym_bad   = sym_bad;
        status.no_room   = no_room;
        status.t_zero    = (ta_rd == '0);
        status.t_is_q    = (ta_rd == q_reg);
        status.p_zero    = (p_reg == '0);
        status.len_match = (lenp_inc == ln_rd);
        status.idx_last  = (idx_reg == IDX_W'(ALPHABET - 1));
        status.idx_done  = (idx_reg == IDX_W'(ALPHABET));
        status.out_free  = out_free;
    end

    // Memory port steering
    always_comb
    begin
        ta_we    = 1'b0;
        ta_waddr = pc_addr;
        ta_wdata = '0;
        ta_re    = 1'b0;
        ta_raddr = pc_addr;
        ln_we    = 1'b0;
        ln_waddr = cur_reg;
        ln_wdata = '0;
        ln_re    = 1'b0;
        ln_raddr = p_reg;
        lk_we    = 1'b0;
        lk_waddr = cur_reg;
        lk_wdata = '0;
        lk_re    = 1'b0;
        lk_raddr = p_reg;
        case (cmd.op)
            sae_pkg::OP_CLR0:
            begin
                ta_we    = 1'b1;
                ta_waddr = idx_ext;
                ln_we    = (idx_reg == '0);
                ln_waddr = '0;
                lk_we    = (idx_reg == '0);
                lk_waddr = '0;
            end
            sae_pkg::OP_ACCEPT:
            begin
                ln_re    = 1'b1;
                ln_raddr = last_reg;
            end
            sae_pkg::OP_SETCUR:
            begin
                ln_we    = 1'b1;
                ln_wdata = ln_rd + CNT_W'(1);
                lk_we    = 1'b1;
            end
            sae_pkg::OP_CLRROW:
            begin
                ta_we    = 1'b1;
                ta_waddr = TA_W'(cur_row + idx_ext);
            end
            sae_pkg::OP_WALK_RD:
            begin
                ta_re = 1'b1;
                ln_re = 1'b1;
                lk_re = 1'b1;
            end
            sae_pkg::OP_WALK_CHK:
            begin
                if (ta_rd == '0)
                begin
                    ta_we    = 1'b1;
                    ta_wdata = cur_reg;
                end
                else
                begin
                    ln_re    = 1'b1;
                    ln_raddr = ta_rd;
                    lk_re    = 1'b1;
                    lk_raddr = ta_rd;
                end
            end
            sae_pkg::OP_CMP:
            begin
                if (lenp_inc == ln_rd)
                begin
                    lk_we    = 1'b1;
                    lk_wdata = q_reg;
                end
            end
            sae_pkg::OP_COPY:
            begin
                ta_re    = (idx_reg != IDX_W'(ALPHABET));
                ta_raddr = TA_W'(q_row + idx_ext);
                ta_we    = (idx_reg != '0);
                ta_waddr = TA_W'(clone_row + idx_prev);
                ta_wdata = ta_rd;
            end
            sae_pkg::OP_CLONE_META:
            begin
                ln_we    = 1'b1;
                ln_waddr = clone_reg;
                ln_wdata = lenp_inc;
                lk_we    = 1'b1;
                lk_waddr = clone_reg;
                lk_wdata = linkq_reg;
            end
            sae_pkg::OP_RED_RD:
            begin
                ta_re = 1'b1;
                lk_re = 1'b1;
            end
            sae_pkg::OP_RED_CHK:
            begin
                if (ta_rd == q_reg)
                begin
                    ta_we    = 1'b1;
                    ta_wdata = clone_reg;
                end
            end
            sae_pkg::OP_LINKQ:
            begin
                lk_we    = 1'b1;
                lk_waddr = q_reg;
                lk_wdata = clone_reg;
            end
            sae_pkg::OP_LINKCUR:
            begin
                lk_we    = 1'b1;
                lk_wdata = clone_reg;
            end
            sae_pkg::OP_FIN_RD:
            begin
                ln_re    = 1'b1;
                ln_raddr = lnk_reg;
            end
            default:
            begin
                ta_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CNT_W'(1);
            last_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                sae_pkg::OP_CLR0, sae_pkg::OP_CLRROW:
                begin
                    idx_reg <= status.idx_last ? '0 : idx_reg + IDX_W'(1);
                end
                sae_pkg::OP_ACCEPT:
                begin
                    if (!sym_bad && !no_room)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                sae_pkg::OP_SETCUR:
                begin
                    idx_reg <= '0;
                end
                sae_pkg::OP_CMP:
                begin
                    idx_reg <= '0;
                    if (lenp_inc != ln_rd)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                sae_pkg::OP_COPY:
                begin
                    idx_reg <= status.idx_done ? '0 : idx_reg + IDX_W'(1);
                end
                sae_pkg::OP_FIN:
                begin
                    last_reg <= cur_reg;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
            if (cmd.op == sae_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sae_pkg::OP_ACCEPT:
            begin
                sym_reg      <= SYM_W'(symbol);
                cur_reg      <= ST_W'(count_reg);
                res_new_reg  <= '0;
                res_link_reg <= '0;
                res_len_reg  <= '0;
                res_da_reg   <= '0;
                res_used_reg <= count_reg;
                res_full_reg <= no_room && !sym_bad;
            end
            sae_pkg::OP_SETCUR:
            begin
                lencur_reg <= ln_rd + CNT_W'(1);
                p_reg      <= last_reg;
            end
            sae_pkg::OP_WALK_CHK:
            begin
                if (ta_rd != '0)
                begin
                    q_reg    <= ta_rd;
                    lenp_reg <= ln_rd;
                end
                else if (p_reg == '0)
                begin
                    lnk_reg <= '0;
                end
                else
                begin
                    p_reg <= lk_rd;
                end
            end
            sae_pkg::OP_CMP:
            begin
                linkq_reg <= lk_rd;
                clone_reg <= ST_W'(count_reg);
                lnk_reg   <= q_reg;
            end
            sae_pkg::OP_RED_CHK:
            begin
                p_reg <= lk_rd;
            end
            sae_pkg::OP_LINKCUR:
            begin
                lnk_reg <= clone_reg;
            end
            sae_pkg::OP_FIN:
            begin
                res_new_reg  <= cur_reg;
                res_link_reg <= lnk_reg;
                res_len_reg  <= lencur_reg;
                res_da_reg   <= lencur_reg - ln_rd;
                res_used_reg <= count_reg;
                res_full_reg <= 1'b0;
            end
            sae_pkg::OP_EMIT:
            begin
                out_new_reg  <= sae_pkg::STATE_W'(res_new_reg);
                out_link_reg <= sae_pkg::STATE_W'(res_link_reg);
                out_len_reg  <= sae_pkg::LENGTH_W'(res_len_reg);
                out_da_reg   <= sae_pkg::LENGTH_W'(res_da_reg);
                out_used_reg <= sae_pkg::USED_W'(res_used_reg);
                out_full_reg <= res_full_reg;
            end
            default:
            begin
                sym_reg <= sym_reg;
            end
        endcase
    end

    // Stores
    sae_ram #(.WIDTH(ST_W), .DEPTH(TA_D)) u_trans (
        .clk   (clk),
        .we    (ta_we),
        .waddr (ta_waddr),
        .wdata (ta_wdata),
        .re    (ta_re),
        .raddr (ta_raddr),
        .rdata (ta_rd)
    );

    sae_ram #(.WIDTH(CNT_W), .DEPTH(MAX_STATES)) u_len (
        .clk   (clk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .re    (ln_re),
        .raddr (ln_raddr),
        .rdata (ln_rd)
    );

    sae_ram #(.WIDTH(ST_W), .DEPTH(MAX_STATES)) u_link (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .re    (lk_re),
        .raddr (lk_raddr),
        .rdata (lk_rd)
    );

    assign out_valid      = out_valid_reg;
    assign new_state      = out_new_reg;
    assign link_state     = out_link_reg;
    assign new_length     = out_len_reg;
    assign distinct_added = out_da_reg;
    assign states_used    = out_used_reg;
    assign store_full     = out_full_reg;

`ifndef ASSERT_OFF
    // State count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_STATES))
        else $error("state count above capacity");

    // A transition found during the walk points at an allocated state
    a_target_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sae_pkg::OP_WALK_CHK && ta_rd != '0) |->
            (CNT_W'(ta_rd) < count_reg))
        else $error("transition to unallocated state");

    // An accepted letter with room allocates exactly one state
    a_alloc_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sae_pkg::OP_ACCEPT && !sym_bad && !no_room) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("allocation count slip");

    // A finished result never adds more substrings than its length
    a_da_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sae_pkg::OP_FIN) |=> (res_da_reg <= res_len_reg))
        else $error("distinct count above length");
`endif

endmodule

@@ rtl/suffix_automaton_extend.sv @@
// Top level of the suffix automaton extend block.
// Appends one letter per request to a suffix automaton held in three RAMs
// (transitions, suffix links, longest lengths) and returns one result per
// request. After reset the block first clears the root's row before it
// takes a request. A refused letter (out of range or store full) goes
// straight to the result. An accepted letter first clears the new state's
// row in the transition RAM, one entry a cycle, then walks the suffix
// links. When a clone is made its row is copied through the RAM's single
// read port and the transitions that pointed at the split state are
// redirected to the clone. One request is in work at a time; the result
// register lets the next request in while the previous result waits.
module suffix_automaton_extend #(
    parameter int MAX_STATES = 1024,
    parameter int ALPHABET   = 26
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sae_pkg::SYMBOL_W-1:0] symbol,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sae_pkg::STATE_W-1:0]  new_state,
    output logic [sae_pkg::STATE_W-1:0]  link_state,
    output logic [sae_pkg::LENGTH_W-1:0] new_length,
    output logic [sae_pkg::LENGTH_W-1:0] distinct_added,
    output logic [sae_pkg::USED_W-1:0]   states_used,
    output logic                         store_full
);

    sae_pkg::dp_cmd_t    cmd;
    sae_pkg::dp_status_t status;

    sae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sae_dp #(.MAX_STATES(MAX_STATES), .ALPHABET(ALPHABET)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .symbol         (symbol),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .new_state      (new_state),
        .link_state     (link_state),
        .new_length     (new_length),
        .distinct_added (distinct_added),
        .states_used    (states_used),
        .store_full     (store_full)
    );

endmodule

@@ sim/sae_checker.sv @@
// Channel monitor, suffix automaton predictor and result comparison.
`timescale 1ns / 100ps
module sae_checker #(
    parameter int MAX_STATES = 1024,
    parameter int ALPHABET   = 26
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [sae_pkg::SYMBOL_W-1:0] symbol,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [sae_pkg::STATE_W-1:0]  new_state,
    input  logic [sae_pkg::STATE_W-1:0]  link_state,
    input  logic [sae_pkg::LENGTH_W-1:0] new_length,
    input  logic [sae_pkg::LENGTH_W-1:0] distinct_added,
    input  logic [sae_pkg::USED_W-1:0]   states_used,
    input  logic                         store_full,
    output int                           fail_count,
    output int                           pending,
    output int                           full_seen,
    output int                           clones_seen
);

    typedef struct packed {
        logic [sae_pkg::STATE_W-1:0]  st;
        logic [sae_pkg::STATE_W-1:0]  lnk;
        logic [sae_pkg::LENGTH_W-1:0] len;
        logic [sae_pkg::LENGTH_W-1:0] added;
        logic [sae_pkg::USED_W-1:0]   used;
        logic                         full;
    } extend_result_t;

    // Model copy of the automaton
    logic [sae_pkg::STATE_W-1:0] trans [MAX_STATES][ALPHABET];
    logic [sae_pkg::STATE_W-1:0] slink [MAX_STATES];
    int unsigned                 slen  [MAX_STATES];
    int unsigned                 n_states;
    int unsigned                 last_st;

    extend_result_t result_q[$];

    task automatic clear_automaton();
        for (int s = 0; s < MAX_STATES; s++)
        begin
            for (int a = 0; a < ALPHABET; a++)
                trans[s][a] = '0;
            slink[s] = '0;
            slen[s]  = 0;
        end
        n_states = 1;
        last_st  = 0;
    endtask

    // Append one letter and return what the block should report
    task automatic append_letter(input logic [sae_pkg::SYMBOL_W-1:0] sym,
                                 output extend_result_t r);
        int unsigned c, cur, p, q, cl, lk;
        bit found;
        r = '0;
        found = 0;
        if (sym >= ALPHABET)
        begin
            r.used = n_states[sae_pkg::USED_W-1:0];
            return;
        end
        if (n_states + 2 > MAX_STATES)
        begin
            r.used = n_states[sae_pkg::USED_W-1:0];
            r.full = 1'b1;
            full_seen++;
            return;
        end
        c   = sym;
        cur = n_states++;
        slen[cur]  = slen[last_st] + 1;
        slink[cur] = '0;
        p = last_st;
        for (int g = 0; g < MAX_STATES; g++)
        begin
            if (trans[p][c] != 0)
            begin
                found = 1;
                break;
            end
            trans[p][c] = cur[sae_pkg::STATE_W-1:0];
            if (p == 0)
                break;
            p = slink[p];
        end
        if (found)
        begin
            q = trans[p][c];
            if (slen[p] + 1 == slen[q])
                slink[cur] = q[sae_pkg::STATE_W-1:0];
            else
            begin
                // split: clone q and redirect the walk onto it
                cl = n_states++;
                clones_seen++;
                for (int a = 0; a < ALPHABET; a++)
                    trans[cl][a] = trans[q][a];
                slen[cl]  = slen[p] + 1;
                slink[cl] = slink[q];
                for (int g = 0; g < MAX_STATES; g++)
                begin
                    if (trans[p][c] != q)
                        break;
                    trans[p][c] = cl[sae_pkg::STATE_W-1:0];
                    if (p == 0)
                        break;
                    p = slink[p];
                end
                slink[q]   = cl[sae_pkg::STATE_W-1:0];
                slink[cur] = cl[sae_pkg::STATE_W-1:0];
            end
        end
        last_st = cur;
        lk = slink[cur];
        r.st    = cur[sae_pkg::STATE_W-1:0];
        r.lnk   = lk[sae_pkg::STATE_W-1:0];
        r.len   = slen[cur][sae_pkg::LENGTH_W-1:0];
        r.added = sae_pkg::LENGTH_W'(slen[cur] - slen[lk]);
        r.used  = n_states[sae_pkg::USED_W-1:0];
    endtask

    initial
    begin
        fail_count  = 0;
        pending     = 0;
        full_seen   = 0;
        clones_seen = 0;
        clear_automaton();
    end

    // Compare results first, then predict the request taken on this edge
    always @(posedge clk)
    begin
        extend_result_t exp_r, got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{new_state, link_state, new_length, distinct_added,
                        states_used, store_full};
                if (result_q.size() == 0)
                begin
                    $error("result with no request waiting: state %0d", new_state);
                    fail_count++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (got.st !== exp_r.st)
                    begin
                        $error("new_state expected %0d got %0d", exp_r.st, got.st);
                        fail_count++;
                    end
                    if (got.lnk !== exp_r.lnk)
                    begin
                        $error("link_state expected %0d got %0d", exp_r.lnk, got.lnk);
                        fail_count++;
                    end
                    if (got.len !== exp_r.len)
                    begin
                        $error("new_length expected %0d got %0d", exp_r.len, got.len);
                        fail_count++;
                    end
                    if (got.added !== exp_r.added)
                    begin
                        $error("distinct_added expected %0d got %0d", exp_r.added, got.added);
                        fail_count++;
                    end
                    if (got.used !== exp_r.used)
                    begin
                        $error("states_used expected %0d got %0d", exp_r.used, got.used);
                        fail_count++;
                    end
                    if (got.full !== exp_r.full)
                    begin
                        $error("store_full expected %0d got %0d", exp_r.full, got.full);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                append_letter(symbol, exp_r);
                result_q.push_back(exp_r);
            end
            pending = result_q.size();
        end
    end
endmodule

@@ sim/tb_suffix_automaton_extend.sv @@
// Testbench top: stimulus, clock, reset and verdict for suffix_automaton_extend.
`timescale 1ns / 100ps
module tb_suffix_automaton_extend;

    localparam int N_RANDOM    = 1250;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [sae_pkg::SYMBOL_W-1:0] symbol = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [sae_pkg::STATE_W-1:0]  new_state, link_state;
    logic [sae_pkg::LENGTH_W-1:0] new_length, distinct_added;
    logic [sae_pkg::USED_W-1:0]   states_used;
    logic                         store_full;

    int fail_count, pending, full_seen, clones_seen;
    int sent = 0;
    int cycles = 0;
    bit no_idle = 0;

    suffix_automaton_extend u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .symbol(symbol),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_state(new_state), .link_state(link_state), .new_length(new_length),
        .distinct_added(distinct_added), .states_used(states_used),
        .store_full(store_full)
    );

    sae_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .symbol(symbol),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_state(new_state), .link_state(link_state), .new_length(new_length),
        .distinct_added(distinct_added), .states_used(states_used),
        .store_full(store_full),
        .fail_count(fail_count), .pending(pending),
        .full_seen(full_seen), .clones_seen(clones_seen)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL suffix_automaton_extend");
            $finish;
        end
    end

    // Offer one letter request after a random gap; returns once accepted
    task automatic send_letter(input logic [sae_pkg::SYMBOL_W-1:0] sym);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        @(negedge clk);
    endtask

    // Result side: random stalls, one long hold-off early on
    initial
    begin
        int w;
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && sent >= 30)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1;
            end
            w = no_idle ? 0 : $urandom_range(0, 5);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        logic [sae_pkg::SYMBOL_W-1:0] directed[$];
        int alpha, r;
        // repeats, a split-forcing pattern, both ends of the alphabet, out of range
        directed = '{0, 0, 0, 1, 1, 0, 1, 1, 2, 25, 26, 31, 27, 0, 25, 25,
                     1, 0, 1, 0, 2, 30, 3, 28, 29};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_letter(directed[i]);

        // Mostly small alphabets for deep suffix structure, some wide, some invalid
        alpha = 2;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
                alpha = $urandom_range(1, 4);
            no_idle = (i >= 300 && i < 380);
            r = $urandom_range(0, 99);
            if (r < 70)
                send_letter(sae_pkg::SYMBOL_W'($urandom_range(0, alpha - 1)));
            else if (r < 90)
                send_letter(sae_pkg::SYMBOL_W'($urandom_range(0, 25)));
            else
                send_letter(sae_pkg::SYMBOL_W'($urandom_range(26, 31)));
        end
        in_valid <= 1'b0;
        no_idle = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d letters sent, %0d clones predicted, %0d refused as store full",
                 sent, clones_seen, full_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS suffix_automaton_extend");
        else
            $display("FAIL suffix_automaton_extend");
        $finish;
    end
endmodule
